[design/bellman_ford_edge_relax_frontier_unit_defines.svh]
// Assertion helpers for the checker file of this block.
`ifndef BELLMAN_FORD_EDGE_RELAX_FRONTIER_UNIT_DEFINES_SVH
`define BELLMAN_FORD_EDGE_RELAX_FRONTIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BFER_CHECK_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfer check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BFER_CHECK_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfer check failed");

`endif

[design/bfer_pkg.sv]
`default_nettype none

package bfer_pkg;

	// Largest vertex count the memories hold.
	localparam int MAX_VERTICES = 1024;

	// Field widths.
	localparam int VTX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int DIST_W = 31;
	localparam int MODE_W = 2;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Distance code of a vertex that has not been reached.
	localparam logic [DIST_W-1:0] UNREACHED = 31'h7FFF_FFFF;

	// Register reset values.
	localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET  = 11'd1024;
	localparam logic [VTX_W-1:0] SOURCE_VERTEX_RESET = 10'd0;

	// Register index, taken from the word address bit.
	localparam logic REG_VERTEX_COUNT  = 1'b0;
	localparam logic REG_SOURCE_VERTEX = 1'b1;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RELAX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ROUND = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAIL,
		ST_HEAD,
		ST_READ,
		ST_SEED_CLR,
		ST_SEED_SET,
		ST_ROUND,
		ST_ROUND_LAST,
		ST_EMIT
	} state_t;

	// Register contents handed to the engine.
	typedef struct packed {
		logic [CNT_W-1:0] vertex_count;
		logic [VTX_W-1:0] source_vertex;
	} cfg_t;

	// Per-vertex status bits.
	typedef struct packed {
		logic reached;
		logic in_now;
		logic in_next;
	} flags_t;

	// Per-vertex distance and predecessor.
	typedef struct packed {
		logic [DIST_W-1:0] path_dist;
		logic [VTX_W-1:0]  parent;
	} entry_t;

	// One result.
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [VTX_W-1:0]  parent;
		logic              has_parent;
		logic              improved;
		logic              newly_active;
		logic [CNT_W-1:0]  round_active;
		logic              finished;
		logic              error;
	} res_t;

endpackage

`default_nettype wire

[design/bfer_ram.sv]
`default_nettype none

// Simple dual-port memory: one write port, one read port, registered read data.
module bfer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/bfer_cfg_regs.sv]
`default_nettype none

// Register file behind the configuration port.
module bfer_cfg_regs import bfer_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [CNT_W-1:0] vertex_count_q;
	logic [VTX_W-1:0] source_vertex_q;
	logic             reg_idx;
	logic             wr_en;

	// Registers are one word apart, so the word bit selects the register.
	assign reg_idx = paddr[ADDR_W-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= VERTEX_COUNT_RESET;
			source_vertex_q <= SOURCE_VERTEX_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_VERTEX_COUNT:  vertex_count_q  <= pwdata[CNT_W-1:0];
				REG_SOURCE_VERTEX: source_vertex_q <= pwdata[VTX_W-1:0];
				default:           vertex_count_q  <= vertex_count_q;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (reg_idx)
			REG_VERTEX_COUNT:  prdata = DATA_W'(vertex_count_q);
			REG_SOURCE_VERTEX: prdata = DATA_W'(source_vertex_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.vertex_count  = vertex_count_q;
	assign cfg.source_vertex = source_vertex_q;

endmodule

`default_nettype wire

[design/bfer_engine.sv]
`default_nettype none

// Request sequencer and relaxation datapath around the vertex memories.
module bfer_engine import bfer_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [VTX_W-1:0]  edge_src,
	input  wire logic [VTX_W-1:0]  edge_dest,
	input  wire logic [DIST_W-1:0] edge_weight,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output res_t                   res
);

	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int FLAG_W = $bits(flags_t);
	localparam int ENT_W  = $bits(entry_t);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

	state_t state_q, state_d, dispatch;

	// Request registers.
	logic [VTX_W-1:0]  a_q, b_q, src_q;
	logic [DIST_W-1:0] w_q;

	// Sweep counter and the write stage of the frontier swap.
	logic [AW-1:0] idx_q;
	logic          sweep_wr_s1;
	logic [AW-1:0] sweep_addr_s1;

	// Round bookkeeping.
	logic [CNT_W-1:0] round_q, tally_q, tally_eff, round_new;
	logic [CNT_W-1:0] usable_n, limit;

	// Tail vertex data, captured in the tail state while the head read is issued.
	flags_t tail_flags_q, tail_flags_in;
	entry_t tail_ent_q, tail_ent_in;

	// Last relaxation write, forwarded to a read issued at the same edge.
	logic             fwd_valid_q;
	logic [VTX_W-1:0] fwd_vtx_q;
	flags_t           fwd_flags_q;
	entry_t           fwd_ent_q;
	logic             fwd_hit;

	// Results.
	res_t res_q, out_res_q, err_res, round_res, seed_res, relax_res;
	logic out_valid_q, out_free, load_out;

	// Memory ports.
	logic            flag_we, ent_we;
	logic [AW-1:0]   flag_waddr, ent_waddr, rd_addr;
	flags_t          flag_wdata, flag_rd;
	entry_t          ent_wdata, ent_rd;
	logic [VTX_W-1:0] rd_vtx;

	// Handshake and range checks.
	logic can_take, accept, head_fire;
	logic src_bad, a_bad, b_bad;

	// Relaxation datapath.
	logic              active, improve, newly;
	logic [DIST_W:0]   cand, cur;

	function automatic res_t show_vertex(input flags_t f, input entry_t e);
		res_t r;
		r = '0;
		if (f.reached) begin
			r.distance   = e.path_dist;
			r.parent     = e.parent;
			r.has_parent = 1'b1;
		end else begin
			r.distance = UNREACHED;
		end
		return r;
	endfunction

	bfer_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_VERTICES)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (rd_addr),
		.rdata (flag_rd)
	);

	bfer_ram #(.WIDTH(ENT_W), .DEPTH(MAX_VERTICES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (rd_addr),
		.rdata (ent_rd)
	);

	// Usable vertex count and the round limit.
	assign usable_n = (32'(cfg.vertex_count) < 32'(MAX_VERTICES)) ?
		cfg.vertex_count : CNT_W'(MAX_VERTICES);
	assign limit    = (usable_n == '0) ? '0 : usable_n - CNT_W'(1);
	assign src_bad  = {1'b0, cfg.source_vertex} >= usable_n;
	assign a_bad    = {1'b0, edge_src} >= usable_n;
	assign b_bad    = {1'b0, edge_dest} >= usable_n;

	// Handshake: a new request is taken when idle or as a relaxation retires.
	assign out_free  = !out_valid_q || !out_stall;
	assign can_take  = (state_q == ST_IDLE) || (state_q == ST_HEAD && out_free);
	assign in_stall  = !can_take;
	assign accept    = in_valid && can_take;
	assign head_fire = (state_q == ST_HEAD) && out_free;

	// Tail data comes from the memory unless the previous edge just wrote it.
	assign fwd_hit       = fwd_valid_q && (fwd_vtx_q == a_q);
	assign tail_flags_in = fwd_hit ? fwd_flags_q : flag_rd;
	assign tail_ent_in   = fwd_hit ? fwd_ent_q : ent_rd;

	// Relaxation of the tail distance plus weight against the head distance.
	always_comb begin
		active    = tail_flags_q.reached && tail_flags_q.in_now;
		cand      = {1'b0, tail_ent_q.path_dist} + {1'b0, w_q};
		cur       = flag_rd.reached ? {1'b0, ent_rd.path_dist} : {1'b0, UNREACHED};
		improve   = active && (cand < cur);
		newly     = improve && !flag_rd.in_next;
		relax_res = show_vertex(flag_rd, ent_rd);
		if (improve) begin
			relax_res.distance   = cand[DIST_W-1:0];
			relax_res.parent     = a_q;
			relax_res.has_parent = 1'b1;
			relax_res.improved   = 1'b1;
		end
		relax_res.newly_active = newly;
	end

	// Fixed results: errors, round end and the seeded source.
	always_comb begin
		tally_eff = tally_q + {{(CNT_W-1){1'b0}}, head_fire && newly};
		round_new = (round_q == '1) ? round_q : round_q + CNT_W'(1);

		err_res       = '0;
		err_res.error = 1'b1;

		round_res              = '0;
		round_res.round_active = tally_eff;
		round_res.finished     = (tally_eff == '0) || (round_new >= limit);

		seed_res            = '0;
		seed_res.parent     = src_q;
		seed_res.has_parent = 1'b1;
	end

	// Memory read address: head while relaxing, sweep index, else the request.
	always_comb begin
		if (state_q == ST_TAIL || (state_q == ST_HEAD && !out_free)) begin
			rd_vtx = b_q;
		end else begin
			rd_vtx = edge_src;
		end
		rd_addr = (state_q == ST_ROUND) ? idx_q : AW'(rd_vtx);
	end

	// Memory writes.
	always_comb begin
		flag_we    = 1'b0;
		flag_waddr = AW'(b_q);
		flag_wdata = '{reached: 1'b1, in_now: flag_rd.in_now, in_next: 1'b1};
		ent_we     = 1'b0;
		ent_waddr  = AW'(b_q);
		ent_wdata  = '{path_dist: cand[DIST_W-1:0], parent: a_q};
		unique case (state_q) inside
			ST_CLEAR, ST_SEED_CLR: begin
				flag_we    = 1'b1;
				flag_waddr = idx_q;
				flag_wdata = '0;
			end
			ST_SEED_SET: begin
				flag_we    = 1'b1;
				flag_waddr = AW'(src_q);
				flag_wdata = '{reached: 1'b1, in_now: 1'b1, in_next: 1'b0};
				ent_we     = 1'b1;
				ent_waddr  = AW'(src_q);
				ent_wdata  = '{path_dist: '0, parent: src_q};
			end
			ST_ROUND, ST_ROUND_LAST: begin
				flag_we    = sweep_wr_s1;
				flag_waddr = sweep_addr_s1;
				flag_wdata = '{reached: flag_rd.reached, in_now: flag_rd.in_next,
					in_next: 1'b0};
			end
			ST_HEAD: begin
				flag_we = head_fire && improve;
				ent_we  = head_fire && improve;
			end
			default: begin
				flag_we = 1'b0;
			end
		endcase
	end

	// Where a new request goes.
	always_comb begin
		unique case (mode)
			MODE_START: dispatch = src_bad ? ST_EMIT : ST_SEED_CLR;
			MODE_RELAX: dispatch = (a_bad || b_bad) ? ST_EMIT : ST_TAIL;
			MODE_ROUND: dispatch = ST_ROUND;
			MODE_READ:  dispatch = a_bad ? ST_EMIT : ST_READ;
			default:    dispatch = ST_EMIT;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_CLEAR: begin
				if (idx_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE, ST_HEAD: begin
				if (head_fire) state_d = ST_IDLE;
				if (accept) state_d = dispatch;
			end
			ST_TAIL: begin
				state_d = ST_HEAD;
			end
			ST_READ, ST_SEED_SET, ST_ROUND_LAST: begin
				state_d = ST_EMIT;
			end
			ST_SEED_CLR: begin
				if (idx_q == LAST_IDX) state_d = ST_SEED_SET;
			end
			ST_ROUND: begin
				if (idx_q == LAST_IDX) state_d = ST_ROUND_LAST;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign load_out = out_free && (state_q == ST_HEAD || state_q == ST_EMIT);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			sweep_wr_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			round_q     <= '0;
			tally_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sweep_wr_s1 <= (state_q == ST_ROUND);
			fwd_valid_q <= head_fire && improve;

			// Sweep counter restarts with each start or round end.
			if (accept && (mode == MODE_START || mode == MODE_ROUND)) begin
				idx_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SEED_CLR ||
				state_q == ST_ROUND) begin
				idx_q <= idx_q + AW'(1);
			end

			// Round counter and activation tally.
			if (accept && mode == MODE_START && !src_bad) begin
				round_q <= '0;
				tally_q <= '0;
			end else if (accept && mode == MODE_ROUND) begin
				round_q <= round_new;
				tally_q <= '0;
			end else if (head_fire && newly) begin
				tally_q <= tally_eff;
			end

			// Output register.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		sweep_addr_s1 <= idx_q;

		if (accept) begin
			a_q   <= edge_src;
			b_q   <= edge_dest;
			w_q   <= edge_weight;
			src_q <= cfg.source_vertex;
		end

		if (state_q == ST_TAIL) begin
			tail_flags_q <= tail_flags_in;
			tail_ent_q   <= tail_ent_in;
		end

		if (head_fire) begin
			fwd_vtx_q   <= b_q;
			fwd_flags_q <= flag_wdata;
			fwd_ent_q   <= ent_wdata;
		end

		// Pending result for requests that do not retire from the head stage.
		if (accept) begin
			if (dispatch == ST_EMIT) begin
				res_q <= err_res;
			end else if (mode == MODE_ROUND) begin
				res_q <= round_res;
			end
		end else if (state_q == ST_READ) begin
			res_q <= show_vertex(tail_flags_in, tail_ent_in);
		end else if (state_q == ST_SEED_SET) begin
			res_q <= seed_res;
		end

		if (load_out) begin
			out_res_q <= (state_q == ST_HEAD) ? relax_res : res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_res_q;

endmodule

`default_nettype wire

[design/bellman_ford_edge_relax_frontier_unit.sv]
`default_nettype none

// Frontier-driven shortest-path relaxation unit. Software writes vertex_count and
// source_vertex, sends a start request, streams the edges of one round, sends an
// end-of-round request and repeats until a round result shows finished; a read
// request then returns any vertex's distance and parent. Every request gives one
// result. Distances and parents live in one memory, the reached and frontier bits
// in another; both have a single registered read port, and that port sets the
// pace: an edge takes a tail read, then a head read with the add, compare and
// write-back, and the next edge's tail read is issued as the previous edge's
// head retires, with the last write forwarded to it. A read request goes through
// a read state and an emit state; an out-of-range request goes straight to emit.
// Start and end of round each sweep the bit memory one vertex per cycle. After
// reset the unit clears the bit memory before it takes its first request;
// register writes are taken at any time.
module bellman_ford_edge_relax_frontier_unit import bfer_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [VTX_W-1:0]  edge_src,
	input  wire logic [VTX_W-1:0]  edge_dest,
	input  wire logic [DIST_W-1:0] edge_weight,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [DIST_W-1:0] distance,
	output logic      [VTX_W-1:0]  parent,
	output logic                   has_parent,
	output logic                   improved,
	output logic                   newly_active,
	output logic      [CNT_W-1:0]  round_active,
	output logic                   finished,
	output logic                   error
);

	cfg_t cfg;
	res_t res;

	bfer_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfer_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.edge_src    (edge_src),
		.edge_dest   (edge_dest),
		.edge_weight (edge_weight),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res)
	);

	// Result fields onto their ports.
	assign distance     = res.distance;
	assign parent       = res.parent;
	assign has_parent   = res.has_parent;
	assign improved     = res.improved;
	assign newly_active = res.newly_active;
	assign round_active = res.round_active;
	assign finished     = res.finished;
	assign error        = res.error;

endmodule

`default_nettype wire

[design/bfer_checker.sv]
`default_nettype none

`include "bellman_ford_edge_relax_frontier_unit_defines.svh"

// Port-level checks on the result channel.
module bfer_checker import bfer_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DIST_W-1:0] distance,
	input wire logic [VTX_W-1:0]  parent,
	input wire logic              has_parent,
	input wire logic              improved,
	input wire logic              newly_active,
	input wire logic [CNT_W-1:0]  round_active,
	input wire logic              finished,
	input wire logic              error
);

	// A stalled result stays put.
	`BFER_CHECK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(distance) && $stable(parent) && $stable(has_parent) && $stable(round_active) && $stable(error))

	// An error result carries nothing else.
	`BFER_CHECK_IMPL(a_error_clean, clk, arst_n, out_valid && error, distance == '0 && parent == '0 && !has_parent && !improved && !newly_active && round_active == '0 && !finished)

	// A vertex entering the next frontier was improved and is reached.
	`BFER_CHECK_IMPL(a_newly_improved, clk, arst_n, out_valid && newly_active, improved && has_parent && distance != UNREACHED)

	// A round result shows no vertex fields.
	`BFER_CHECK_IMPL(a_round_clean, clk, arst_n, out_valid && (finished || round_active != '0), !has_parent && distance == '0 && parent == '0 && !improved && !error)

	// A vertex without a parent shows the unreached code.
	`BFER_CHECK_IMPL(a_unreached_code, clk, arst_n, out_valid && !has_parent && !error && !finished && round_active == '0, distance == UNREACHED && parent == '0)

endmodule

bind bellman_ford_edge_relax_frontier_unit bfer_checker u_bfer_checker (.*);

`default_nettype wire

[tb/tb_bellman_ford_edge_relax_frontier_unit.sv]
`timescale 1ns / 1ps

import bfer_pkg::*;

localparam int MAXV = MAX_VERTICES;

// Keeps a shadow copy of the distance, parent and frontier state and the list of
// results the unit still owes, in request order.
class sssp_scoreboard;
	logic [CNT_W-1:0]  vertex_count;
	logic [VTX_W-1:0]  source_vertex;
	logic [DIST_W-1:0] dist_mem [MAXV];
	logic [VTX_W-1:0]  par_mem [MAXV];
	bit                reached_f [MAXV];
	bit                now_f [MAXV];
	bit                next_f [MAXV];
	logic [CNT_W-1:0]  round_cnt;
	logic [CNT_W-1:0]  tally;
	bit                last_finished;
	res_t              owed_results [$];
	int                errors;

	function new();
		vertex_count = VERTEX_COUNT_RESET;
		source_vertex = SOURCE_VERTEX_RESET;
		round_cnt = '0;
		tally = '0;
		last_finished = 1'b0;
		errors = 0;
		foreach (dist_mem[i]) begin
			dist_mem[i] = '0;
			par_mem[i] = '0;
		end
	endfunction

	function void set_reg(logic idx, logic [DATA_W-1:0] value);
		if (idx == REG_VERTEX_COUNT) begin
			vertex_count = value[CNT_W-1:0];
		end else begin
			source_vertex = value[VTX_W-1:0];
		end
	endfunction

	// Fills in the distance and parent fields of one vertex.
	function res_t with_vertex(res_t r, int unsigned v);
		if (reached_f[v]) begin
			r.distance = dist_mem[v];
			r.parent = par_mem[v];
			r.has_parent = 1'b1;
		end else begin
			r.distance = UNREACHED;
			r.parent = '0;
			r.has_parent = 1'b0;
		end
		return r;
	endfunction

	// Applies one accepted request to the shadow state and queues its result.
	function void note_request(logic [MODE_W-1:0] md, logic [VTX_W-1:0] a,
			logic [VTX_W-1:0] b, logic [DIST_W-1:0] w);
		res_t r;
		int unsigned n;
		int unsigned lim;
		logic [DIST_W:0] cand;
		logic [DIST_W:0] cur;
		r = '0;
		n = (vertex_count < MAXV) ? vertex_count : MAXV;
		case (md)
			MODE_START: begin
				if (source_vertex >= n) begin
					r.error = 1'b1;
				end else begin
					foreach (reached_f[i]) begin
						reached_f[i] = 1'b0;
						now_f[i] = 1'b0;
						next_f[i] = 1'b0;
					end
					dist_mem[source_vertex] = '0;
					par_mem[source_vertex] = source_vertex;
					reached_f[source_vertex] = 1'b1;
					now_f[source_vertex] = 1'b1;
					round_cnt = '0;
					tally = '0;
					r = with_vertex(r, source_vertex);
				end
			end
			MODE_RELAX: begin
				if (a >= n || b >= n) begin
					r.error = 1'b1;
				end else begin
					// Only tails in the current frontier relax; a sum that reaches the
					// unreached code never wins.
					if (now_f[a] && reached_f[a]) begin
						cand = {1'b0, dist_mem[a]} + {1'b0, w};
						cur = reached_f[b] ? {1'b0, dist_mem[b]} : {1'b0, UNREACHED};
						if (cand < cur) begin
							dist_mem[b] = cand[DIST_W-1:0];
							par_mem[b] = a;
							reached_f[b] = 1'b1;
							r.improved = 1'b1;
							if (!next_f[b]) begin
								next_f[b] = 1'b1;
								tally = tally + 1'b1;
								r.newly_active = 1'b1;
							end
						end
					end
					r = with_vertex(r, b);
				end
			end
			MODE_ROUND: begin
				lim = (n > 0) ? n - 1 : 0;
				now_f = next_f;
				foreach (next_f[i]) begin
					next_f[i] = 1'b0;
				end
				if (round_cnt != '1) begin
					round_cnt = round_cnt + 1'b1;
				end
				r.round_active = tally;
				r.finished = (tally == 0) || (round_cnt >= lim);
				tally = '0;
				last_finished = r.finished;
			end
			MODE_READ: begin
				if (a >= n) begin
					r.error = 1'b1;
				end else begin
					r = with_vertex(r, a);
				end
			end
		endcase
		owed_results.push_back(r);
	endfunction

	function void compare_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares one accepted result with the oldest outstanding one.
	function void check_result(res_t got);
		res_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: result with no request outstanding: expected none, got %h",
				$time, got);
			errors++;
			return;
		end
		want = owed_results.pop_front();
		compare_field("distance", want.distance, got.distance);
		compare_field("parent", want.parent, got.parent);
		compare_field("has_parent", want.has_parent, got.has_parent);
		compare_field("improved", want.improved, got.improved);
		compare_field("newly_active", want.newly_active, got.newly_active);
		compare_field("round_active", want.round_active, got.round_active);
		compare_field("finished", want.finished, got.finished);
		compare_field("error", want.error, got.error);
	endfunction
endclass

module tb_bellman_ford_edge_relax_frontier_unit;
	localparam int HOLD_CYCLES = 400;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [MODE_W-1:0] mode;
	logic [VTX_W-1:0]  edge_src;
	logic [VTX_W-1:0]  edge_dest;
	logic [DIST_W-1:0] edge_weight;
	logic              out_valid;
	logic              out_stall;
	logic [DIST_W-1:0] distance;
	logic [VTX_W-1:0]  parent;
	logic              has_parent;
	logic              improved;
	logic              newly_active;
	logic [CNT_W-1:0]  round_active;
	logic              finished;
	logic              error;

	sssp_scoreboard sb = new();

	int          sent_count;
	int          burst_left;
	bit          no_gaps;
	bit          hold_req;
	int unsigned cur_n;
	int unsigned win_lo;
	int unsigned win_sz;

	bellman_ford_edge_relax_frontier_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.edge_src(edge_src),
		.edge_dest(edge_dest),
		.edge_weight(edge_weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.parent(parent),
		.has_parent(has_parent),
		.improved(improved),
		.newly_active(newly_active),
		.round_active(round_active),
		.finished(finished),
		.error(error)
	);

	always #10 clk = ~clk;

	// Watch both handshakes; the result fields concatenate in the order of res_t.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_request(mode, edge_src, edge_dest, edge_weight);
			end
			if (out_valid && !out_stall) begin
				sb.check_result({distance, parent, has_parent, improved, newly_active,
					round_active, finished, error});
			end
		end
	end

	// Result side: segments of no, light, heavy or even stalling, plus a long
	// hold-off whenever the request side asks for one.
	initial begin
		int seg;
		int kind;
		out_stall = 1'b0;
		forever begin
			seg = $urandom_range(16, 160);
			kind = $urandom_range(0, 3);
			repeat (seg) begin
				@(negedge clk);
				if (hold_req) begin
					out_stall = 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				case (kind)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 9) < 7);
					default: out_stall = $urandom_range(0, 1);
				endcase
			end
		end
	end

	// Bursts of random length with random gaps; the payload is scrambled while idle.
	task automatic pace();
		int gap;
		if (burst_left == 0 && !no_gaps) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				mode = MODE_W'($urandom);
				edge_src = VTX_W'($urandom);
				edge_dest = VTX_W'($urandom);
				edge_weight = DIST_W'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic send_request(input logic [MODE_W-1:0] md, input logic [VTX_W-1:0] a,
			input logic [VTX_W-1:0] b, input logic [DIST_W-1:0] w);
		pace();
		in_valid = 1'b1;
		mode = md;
		edge_src = a;
		edge_dest = b;
		edge_weight = w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// Stop offering requests until every outstanding result has come back.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.owed_results.size() != 0) @(negedge clk);
	endtask

	// Register write followed by a read back of the same register.
	task automatic reg_write(input logic idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] want;
		want = (idx == REG_VERTEX_COUNT) ? DATA_W'(value[CNT_W-1:0])
			: DATA_W'(value[VTX_W-1:0]);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d read back: expected %0d, got %0d", $time, idx,
				want, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(input int unsigned vc, input int unsigned sv);
		wait_drained();
		reg_write(REG_VERTEX_COUNT, vc);
		reg_write(REG_SOURCE_VERTEX, sv);
		cur_n = vc;
	endtask

	function automatic logic [DIST_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return DIST_W'($urandom_range(0, 15));
		else if (r < 70) return DIST_W'($urandom_range(0, 1000));
		else if (r < 85) return DIST_W'($urandom);
		else if (r < 95) return DIST_W'(UNREACHED - $urandom_range(0, 15));
		return '0;
	endfunction

	// Mostly vertices near the source, sometimes anywhere or at the range boundary.
	function automatic logic [VTX_W-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return VTX_W'(win_lo + $urandom_range(0, win_sz - 1));
		else if (r < 92) return VTX_W'($urandom_range(0, MAXV - 1));
		else if (r < 96) return VTX_W'(cur_n - 1);
		return VTX_W'((cur_n > MAXV - 1) ? MAXV - 1 : cur_n);
	endfunction

	// One round of edges with some reads, noise and the odd restart, then its end.
	task automatic run_round();
		int r;
		repeat ($urandom_range(3, 24)) begin
			r = $urandom_range(0, 99);
			if (r < 88) begin
				send_request(MODE_RELAX, pick_vertex(), pick_vertex(), pick_weight());
			end else if (r < 94) begin
				send_request(MODE_READ, pick_vertex(), VTX_W'($urandom), DIST_W'($urandom));
			end else if (r < 98) begin
				send_request(MODE_RELAX, VTX_W'($urandom), VTX_W'($urandom),
					DIST_W'($urandom));
			end else begin
				send_request(MODE_START, VTX_W'($urandom), VTX_W'($urandom),
					DIST_W'($urandom));
			end
		end
		send_request(MODE_ROUND, VTX_W'($urandom), VTX_W'($urandom), DIST_W'($urandom));
	endtask

	// Back-to-back requests while the result side holds off, so the unit backs up.
	task automatic flood_during_hold();
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (48) begin
			if ($urandom_range(0, 3) == 0) begin
				send_request(MODE_READ, pick_vertex(), VTX_W'($urandom), DIST_W'($urandom));
			end else begin
				send_request(MODE_RELAX, pick_vertex(), pick_vertex(), pick_weight());
			end
		end
		no_gaps = 1'b0;
	endtask

	// One full run: set up the graph size and source, start, relax rounds until
	// finished, then read vertices back.
	task automatic run_session(input bit with_hold);
		int unsigned vc;
		int unsigned sv;
		int rounds;
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) vc = $urandom_range(2, 12);
		else if (r < 75) vc = 1;
		else if (r < 88) vc = $urandom_range(13, 64);
		else vc = MAXV;
		if (vc < MAXV && $urandom_range(0, 9) == 0) begin
			sv = $urandom_range(vc, MAXV - 1);
		end else begin
			sv = $urandom_range(0, vc - 1);
		end
		configure(vc, sv);
		win_sz = (vc < 16) ? vc : 16;
		win_lo = (sv >= vc) ? 0 : ((sv > vc - win_sz) ? vc - win_sz : sv);
		send_request(MODE_START, VTX_W'($urandom), VTX_W'($urandom), DIST_W'($urandom));
		if (with_hold) begin
			flood_during_hold();
		end
		rounds = 0;
		do begin
			run_round();
			rounds++;
			// Now and then a register changes between rounds without a restart.
			if (!sb.last_finished && $urandom_range(0, 11) == 0) begin
				wait_drained();
				if ($urandom_range(0, 1) == 0) begin
					cur_n = $urandom_range(1, MAXV);
					reg_write(REG_VERTEX_COUNT, cur_n);
				end else begin
					reg_write(REG_SOURCE_VERTEX, $urandom_range(0, MAXV - 1));
				end
			end
		end while (!sb.last_finished && rounds < 14);
		// Requests after the finish still act.
		if ($urandom_range(0, 3) == 0) begin
			run_round();
		end
		repeat ($urandom_range(2, win_sz + 2)) begin
			send_request(MODE_READ, pick_vertex(), VTX_W'($urandom), DIST_W'($urandom));
		end
	endtask

	initial begin
		int sessions;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = MODE_START;
		edge_src = '0;
		edge_dest = '0;
		edge_weight = '0;
		hold_req = 1'b0;
		no_gaps = 1'b0;
		burst_left = 0;
		sent_count = 0;
		cur_n = VERTEX_COUNT_RESET;
		win_lo = 0;
		win_sz = 16;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Before any start: nothing reached, empty frontier, round end finishes.
		send_request(MODE_READ, '0, '0, '0);
		send_request(MODE_READ, VTX_W'(MAXV - 1), '1, '1);
		send_request(MODE_RELAX, '0, VTX_W'(MAXV - 1), UNREACHED);
		send_request(MODE_ROUND, '0, '0, '0);

		// Source outside the graph is refused.
		configure(4, 7);
		send_request(MODE_START, '0, '0, '0);

		// Small graph from vertex 3: first improvement, equal path, better path,
		// sums that reach the unreached code, range errors, tails off the frontier.
		configure(4, 3);
		send_request(MODE_START, '0, '0, '0);
		send_request(MODE_RELAX, 10'd3, 10'd0, 31'd5);
		send_request(MODE_RELAX, 10'd3, 10'd0, 31'd5);
		send_request(MODE_RELAX, 10'd3, 10'd0, 31'd2);
		send_request(MODE_RELAX, 10'd3, 10'd1, UNREACHED);
		send_request(MODE_RELAX, 10'd3, 10'd1, UNREACHED - 1'b1);
		send_request(MODE_RELAX, 10'd4, 10'd0, 31'd1);
		send_request(MODE_RELAX, 10'd0, 10'd4, 31'd1);
		send_request(MODE_RELAX, 10'd0, 10'd2, 31'd1);
		send_request(MODE_ROUND, '0, '0, '0);
		send_request(MODE_RELAX, 10'd1, 10'd2, 31'd1);
		send_request(MODE_RELAX, 10'd0, 10'd2, 31'd7);
		send_request(MODE_RELAX, 10'd0, 10'd3, 31'd0);
		send_request(MODE_READ, 10'd4, '0, '0);
		send_request(MODE_READ, 10'd3, '0, '0);
		send_request(MODE_ROUND, '0, '0, '0);
		send_request(MODE_ROUND, '0, '0, '0);

		// Largest graph with the top vertex as source.
		configure(MAXV, MAXV - 1);
		send_request(MODE_START, '1, '1, '1);
		send_request(MODE_RELAX, VTX_W'(MAXV - 1), '0, UNREACHED);
		send_request(MODE_RELAX, VTX_W'(MAXV - 1), VTX_W'(MAXV - 2), '0);

		// Random runs; the first one and a few later ones include a long hold-off.
		sessions = 0;
		while (sent_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			run_session(sessions == 0 || $urandom_range(0, 7) == 0);
			sessions++;
		end

		wait_drained();
		repeat (MAXV + 16) @(negedge clk);
		if (sb.errors == 0) begin
			$display("bellman_ford_edge_relax_frontier_unit test passed");
		end else begin
			$display("bellman_ford_edge_relax_frontier_unit test failed");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#40_000_000;
		$display("bellman_ford_edge_relax_frontier_unit test failed");
		$finish;
	end
endmodule
